// ===== rtl/midi_track_event_parser_top_assert.svh =====
// assertion macros for the midi track event parser
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked outside reset
`define MTEP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define MTEP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MTEP_ASSERT(label, prop, msg)
`define MTEP_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== rtl/mtep_pkg.sv =====
// ----------------------------------------------------------------------------
// mtep_pkg
// Types, constants and helpers shared by the track event parser files.
// ----------------------------------------------------------------------------
`default_nettype none

package mtep_pkg;

  localparam logic [7:0]  DATA_MASK     = 8'h7F;
  localparam logic [7:0]  STATUS_BIT    = 8'h80;
  localparam logic [7:0]  META_TEMPO    = 8'h51;
  localparam logic [7:0]  STATUS_META   = 8'hFF;
  localparam logic [7:0]  STATUS_SYSEX  = 8'hF0;
  localparam logic [7:0]  STATUS_ESCAPE = 8'hF7;
  localparam logic [3:0]  HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0]  HI_NOTE_ON    = 4'h9;
  localparam logic [3:0]  HI_POLY_AT    = 4'hA;
  localparam logic [3:0]  HI_CTRL       = 4'hB;
  localparam logic [3:0]  HI_PROGRAM    = 4'hC;
  localparam logic [3:0]  HI_CHAN_AT    = 4'hD;
  localparam logic [3:0]  HI_PITCH      = 4'hE;
  localparam logic [23:0] DEFAULT_TEMPO = 24'd500000;
  localparam logic [31:0] TEMPO_LEN     = 32'd3;

  typedef enum logic [9:0] {
    PH_DELTA      = 10'b00_0000_0001,
    PH_STATUS     = 10'b00_0000_0010,
    PH_DATA1      = 10'b00_0000_0100,
    PH_DATA2      = 10'b00_0000_1000,
    PH_META_TYPE  = 10'b00_0001_0000,
    PH_META_LEN   = 10'b00_0010_0000,
    PH_META_TEMPO = 10'b00_0100_0000,
    PH_META_SKIP  = 10'b00_1000_0000,
    PH_SYSEX_LEN  = 10'b01_0000_0000,
    PH_SYSEX_SKIP = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [31:0] event_tick;
    logic [7:0]  status_value;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [1:0]  data_count;
    logic        is_tempo;
    logic [23:0] tempo_value;
  } event_t;

  function automatic logic two_data(input logic [7:0] s);
    logic [3:0] hi;
    hi = s[7:4];
    return (hi == HI_NOTE_OFF) || (hi == HI_NOTE_ON) || (hi == HI_POLY_AT) ||
           (hi == HI_CTRL) || (hi == HI_PITCH);
  endfunction

  function automatic logic one_data(input logic [7:0] s);
    logic [3:0] hi;
    hi = s[7:4];
    return (hi == HI_PROGRAM) || (hi == HI_CHAN_AT);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mtep_in_if.sv =====
// ----------------------------------------------------------------------------
// mtep_in_if
// Byte channel into the track event parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] track_byte;
  logic       track_start;

  modport source (output valid, output track_byte, output track_start, input ready);
  modport sink (input valid, input track_byte, input track_start, output ready);
endinterface

`default_nettype wire

// ===== rtl/mtep_out_if.sv =====
// ----------------------------------------------------------------------------
// mtep_out_if
// Event channel out of the track event parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtep_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] event_tick;
  logic [7:0]  status_value;
  logic [7:0]  first_data;
  logic [7:0]  second_data;
  logic [1:0]  data_count;
  logic        is_tempo;
  logic [23:0] tempo_value;

  modport source (output valid, output event_tick, output status_value,
                  output first_data, output second_data, output data_count,
                  output is_tempo, output tempo_value, input ready);
  modport sink (input valid, input event_tick, input status_value,
                input first_data, input second_data, input data_count,
                input is_tempo, input tempo_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/midi_track_event_parser_top.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_parser_top
// Track chunk body parser: one byte in, at most one decoded event out.
// ----------------------------------------------------------------------------
// The parser decodes every byte in a single pass through the phase logic;
// an event caused by a byte goes into the output register, or into the skid
// register while the output is held. Throughput is one byte per cycle while
// input ready is high, set by the phase decode and the 32-bit tick adder that
// follows each delta. The event channel has an output register and a
// one-entry skid register, so a byte is still taken while one event waits on
// the output; input ready drops only while both entries are full.
`default_nettype none
`include "midi_track_event_parser_top_assert.svh"

module midi_track_event_parser_top (
  input  wire        clk,
  input  wire        rst,
  mtep_in_if.sink    track_in,
  mtep_out_if.source event_out
);

  mtep_pkg::phase_t phase, phase_next;
  logic [31:0] tick_total, tick_total_next;
  logic [7:0]  running_status, running_status_next;
  logic [7:0]  current_status, current_status_next;
  logic [31:0] varlen_accum, varlen_accum_next;
  logic [7:0]  held_data, held_data_next;
  logic [7:0]  meta_type, meta_type_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [23:0] tempo_accum, tempo_accum_next;

  // state as seen by this byte, after an optional start clear
  mtep_pkg::phase_t c_phase;
  logic [31:0] c_tick, c_varlen;
  logic [7:0]  c_running, c_current;

  mtep_pkg::event_t res, out_data, skid_data;
  logic res_valid, out_valid, skid_valid;
  logic accept, out_free;

  logic [7:0]  b;
  logic [31:0] vadd, bytes_dec;
  logic [7:0]  rs;
  logic        is_status;

  assign track_in.ready = !skid_valid;
  assign accept = track_in.valid && track_in.ready;
  assign b = track_in.track_byte;

  always_comb begin
    c_phase   = track_in.track_start ? mtep_pkg::PH_DELTA : phase;
    c_tick    = track_in.track_start ? 32'd0 : tick_total;
    c_varlen  = track_in.track_start ? 32'd0 : varlen_accum;
    c_running = track_in.track_start ? 8'd0 : running_status;
    c_current = track_in.track_start ? 8'd0 : current_status;

    vadd      = {c_varlen[24:0], b[6:0]};
    bytes_dec = bytes_left - 32'd1;
    is_status = (b & mtep_pkg::STATUS_BIT) != 8'd0;
    rs        = is_status ? b : c_running;

    phase_next          = c_phase;
    tick_total_next     = c_tick;
    varlen_accum_next   = c_varlen;
    running_status_next = c_running;
    current_status_next = c_current;
    held_data_next      = held_data;
    meta_type_next      = meta_type;
    bytes_left_next     = bytes_left;
    tempo_accum_next    = tempo_accum;

    res_valid        = 1'b0;
    res.event_tick   = c_tick;
    res.status_value = 8'd0;
    res.first_data   = 8'd0;
    res.second_data  = 8'd0;
    res.data_count   = 2'd0;
    res.is_tempo     = 1'b0;
    res.tempo_value  = mtep_pkg::DEFAULT_TEMPO;

    case (c_phase)
      mtep_pkg::PH_DELTA: begin
        varlen_accum_next = vadd;
        if (!is_status) begin
          tick_total_next   = c_tick + vadd;
          varlen_accum_next = 32'd0;
          phase_next        = mtep_pkg::PH_STATUS;
        end
      end
      mtep_pkg::PH_STATUS: begin
        running_status_next = rs;
        current_status_next = rs;
        varlen_accum_next   = 32'd0;
        if (mtep_pkg::two_data(rs) || mtep_pkg::one_data(rs)) begin
          if (is_status) begin
            phase_next = mtep_pkg::PH_DATA1;
          end else if (mtep_pkg::two_data(rs)) begin
            held_data_next = b;
            phase_next     = mtep_pkg::PH_DATA2;
          end else begin
            res_valid        = 1'b1;
            res.status_value = rs;
            res.first_data   = b;
            res.data_count   = 2'd1;
            phase_next       = mtep_pkg::PH_DELTA;
          end
        end else if (rs == mtep_pkg::STATUS_META) begin
          if (is_status) begin
            phase_next = mtep_pkg::PH_META_TYPE;
          end else begin
            meta_type_next = b;
            phase_next     = mtep_pkg::PH_META_LEN;
          end
        end else if (rs == mtep_pkg::STATUS_SYSEX || rs == mtep_pkg::STATUS_ESCAPE) begin
          if (is_status) begin
            phase_next = mtep_pkg::PH_SYSEX_LEN;
          end else begin
            // one-byte length taken straight from this data byte
            bytes_left_next = {25'd0, b[6:0]};
            phase_next = (b[6:0] == 7'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SYSEX_SKIP;
          end
        end else begin
          res_valid        = 1'b1;
          res.status_value = rs;
          if (is_status) begin
            phase_next = mtep_pkg::PH_DELTA;
          end else begin
            // data byte under unknown status doubles as a one-byte delta
            tick_total_next = c_tick + {25'd0, b[6:0]};
            phase_next      = mtep_pkg::PH_STATUS;
          end
        end
      end
      mtep_pkg::PH_DATA1: begin
        if (mtep_pkg::two_data(c_current)) begin
          held_data_next = b;
          phase_next     = mtep_pkg::PH_DATA2;
        end else begin
          res_valid        = 1'b1;
          res.status_value = c_current;
          res.first_data   = b;
          res.data_count   = 2'd1;
          phase_next       = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_DATA2: begin
        res_valid        = 1'b1;
        res.status_value = c_current;
        res.first_data   = held_data;
        res.second_data  = b;
        res.data_count   = 2'd2;
        phase_next       = mtep_pkg::PH_DELTA;
      end
      mtep_pkg::PH_META_TYPE: begin
        meta_type_next    = b;
        varlen_accum_next = 32'd0;
        phase_next        = mtep_pkg::PH_META_LEN;
      end
      mtep_pkg::PH_META_LEN: begin
        varlen_accum_next = vadd;
        if (!is_status) begin
          bytes_left_next   = vadd;
          varlen_accum_next = 32'd0;
          if (vadd == 32'd0) begin
            res_valid        = 1'b1;
            res.status_value = mtep_pkg::STATUS_META;
            phase_next       = mtep_pkg::PH_DELTA;
          end else if (meta_type == mtep_pkg::META_TEMPO && vadd == mtep_pkg::TEMPO_LEN) begin
            tempo_accum_next = 24'd0;
            phase_next       = mtep_pkg::PH_META_TEMPO;
          end else begin
            phase_next = mtep_pkg::PH_META_SKIP;
          end
        end
      end
      mtep_pkg::PH_META_TEMPO: begin
        tempo_accum_next = {tempo_accum[15:0], b};
        bytes_left_next  = bytes_dec;
        if (bytes_dec == 32'd0) begin
          res_valid        = 1'b1;
          res.status_value = mtep_pkg::STATUS_META;
          res.is_tempo     = 1'b1;
          res.tempo_value  = {tempo_accum[15:0], b};
          phase_next       = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_META_SKIP: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == 32'd0) begin
          res_valid        = 1'b1;
          res.status_value = mtep_pkg::STATUS_META;
          phase_next       = mtep_pkg::PH_DELTA;
        end
      end
      mtep_pkg::PH_SYSEX_LEN: begin
        varlen_accum_next = vadd;
        if (!is_status) begin
          bytes_left_next   = vadd;
          varlen_accum_next = 32'd0;
          phase_next = (vadd == 32'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SYSEX_SKIP;
        end
      end
      mtep_pkg::PH_SYSEX_SKIP: begin
        bytes_left_next = bytes_dec;
        if (bytes_dec == 32'd0) begin
          phase_next = mtep_pkg::PH_DELTA;
        end
      end
      default: begin
        phase_next = mtep_pkg::PH_DELTA;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= mtep_pkg::PH_DELTA;
      tick_total     <= 32'd0;
      running_status <= 8'd0;
      current_status <= 8'd0;
      varlen_accum   <= 32'd0;
      held_data      <= 8'd0;
      meta_type      <= 8'd0;
      bytes_left     <= 32'd0;
      tempo_accum    <= 24'd0;
    end else if (accept) begin
      phase          <= phase_next;
      tick_total     <= tick_total_next;
      running_status <= running_status_next;
      current_status <= current_status_next;
      varlen_accum   <= varlen_accum_next;
      held_data      <= held_data_next;
      meta_type      <= meta_type_next;
      bytes_left     <= bytes_left_next;
      tempo_accum    <= tempo_accum_next;
    end
  end

  // output register plus skid entry
  assign out_free = !out_valid || event_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept && res_valid) begin
        out_data <= res;
      end
    end else if (accept && res_valid) begin
      skid_data <= res;
    end
  end

  assign event_out.valid        = out_valid;
  assign event_out.event_tick   = out_data.event_tick;
  assign event_out.status_value = out_data.status_value;
  assign event_out.first_data   = out_data.first_data;
  assign event_out.second_data  = out_data.second_data;
  assign event_out.data_count   = out_data.data_count;
  assign event_out.is_tempo     = out_data.is_tempo;
  assign event_out.tempo_value  = out_data.tempo_value;

  `MTEP_ASSERT_ALWAYS(a_skid_needs_out, skid_valid |-> out_valid, "skid full with output empty")
  `MTEP_ASSERT(a_skid_blocks_in, skid_valid |-> !track_in.ready, "byte taken while skid full")
  `MTEP_ASSERT(a_tempo_is_meta,
    (out_valid && out_data.is_tempo) |-> (out_data.status_value == mtep_pkg::STATUS_META),
    "tempo event without meta status")
  `MTEP_ASSERT(a_count_range, out_valid |-> (out_data.data_count != 2'd3), "bad data count")
  `MTEP_ASSERT(a_tempo_no_data,
    (out_valid && out_data.is_tempo) |-> (out_data.data_count == 2'd0),
    "tempo event carries channel data")

endmodule

`default_nettype wire

// ===== test/midi_track_event_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser_checker
// Watches the byte and event channels of the track parser. Each accepted byte
// runs through a local copy of the parse logic. Any event it yields is queued
// and compared in order with the events that the parser hands out.
// ----------------------------------------------------------------------------

module midi_track_event_parser_checker (
  input  logic clk,
  input  logic rst,
  mtep_in_if   track_in,
  mtep_out_if  event_out,
  output int   event_errors,
  output int   events_due
);
  import mtep_pkg::*;

  phase_t      phase;
  logic [31:0] tick_sum;
  logic [7:0]  run_status;
  logic [7:0]  cur_status;
  logic [31:0] len_accum;
  logic [7:0]  first_byte;
  logic [7:0]  meta_kind;
  logic [31:0] remaining;
  logic [23:0] tempo_shift;

  event_t      pending_events [$];
  event_t      predicted;
  event_t      observed;
  event_t      wanted;
  logic        produced;
  int          failures = 0;

  function automatic int data_bytes(input logic [7:0] s);
    case (s[7:4])
      HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL, HI_PITCH: return 2;
      HI_PROGRAM, HI_CHAN_AT: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic event_t make_event(input logic [7:0] s, input logic [7:0] d1,
                                        input logic [7:0] d2, input logic [1:0] n,
                                        input logic tempo_flag, input logic [23:0] tempo);
    event_t e;
    e.event_tick   = tick_sum;
    e.status_value = s;
    e.first_data   = d1;
    e.second_data  = d2;
    e.data_count   = n;
    e.is_tempo     = tempo_flag;
    e.tempo_value  = tempo;
    return e;
  endfunction

  task automatic clear_parser();
    phase       = PH_DELTA;
    tick_sum    = '0;
    run_status  = '0;
    cur_status  = '0;
    len_accum   = '0;
    first_byte  = '0;
    meta_kind   = '0;
    remaining   = '0;
    tempo_shift = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic start,
                            output logic got_event, output event_t ev);
    logic again;
    got_event = 1'b0;
    ev        = '0;
    if (start) clear_parser();
    do begin
      again = 1'b0;
      case (phase)
        PH_DELTA: begin
          len_accum = {len_accum[24:0], b[6:0]};
          if (!b[7]) begin
            tick_sum  = tick_sum + len_accum;
            len_accum = '0;
            phase     = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b[7]) run_status = b;
          cur_status = run_status;
          len_accum  = '0;
          // a data byte here is replayed in whatever phase the running status picks
          again = !b[7];
          if (data_bytes(cur_status) != 0) begin
            phase = PH_DATA1;
          end else if (cur_status == STATUS_META) begin
            phase = PH_META_TYPE;
          end else if (cur_status == STATUS_SYSEX || cur_status == STATUS_ESCAPE) begin
            phase = PH_SYSEX_LEN;
          end else begin
            got_event = 1'b1;
            ev        = make_event(cur_status, 8'h00, 8'h00, 2'd0, 1'b0, DEFAULT_TEMPO);
            phase     = PH_DELTA;
          end
        end
        PH_DATA1: begin
          if (data_bytes(cur_status) == 2) begin
            first_byte = b;
            phase      = PH_DATA2;
          end else begin
            got_event = 1'b1;
            ev        = make_event(cur_status, b, 8'h00, 2'd1, 1'b0, DEFAULT_TEMPO);
            phase     = PH_DELTA;
          end
        end
        PH_DATA2: begin
          got_event = 1'b1;
          ev        = make_event(cur_status, first_byte, b, 2'd2, 1'b0, DEFAULT_TEMPO);
          phase     = PH_DELTA;
        end
        PH_META_TYPE: begin
          meta_kind = b;
          len_accum = '0;
          phase     = PH_META_LEN;
        end
        PH_META_LEN: begin
          len_accum = {len_accum[24:0], b[6:0]};
          if (!b[7]) begin
            remaining = len_accum;
            len_accum = '0;
            if (remaining == 0) begin
              got_event = 1'b1;
              ev        = make_event(STATUS_META, 8'h00, 8'h00, 2'd0, 1'b0, DEFAULT_TEMPO);
              phase     = PH_DELTA;
            end else if (meta_kind == META_TEMPO && remaining == TEMPO_LEN) begin
              tempo_shift = '0;
              phase       = PH_META_TEMPO;
            end else begin
              phase = PH_META_SKIP;
            end
          end
        end
        PH_META_TEMPO: begin
          tempo_shift = {tempo_shift[15:0], b};
          remaining   = remaining - 32'd1;
          if (remaining == 0) begin
            got_event = 1'b1;
            ev        = make_event(STATUS_META, 8'h00, 8'h00, 2'd0, 1'b1, tempo_shift);
            phase     = PH_DELTA;
          end
        end
        PH_META_SKIP: begin
          remaining = remaining - 32'd1;
          if (remaining == 0) begin
            got_event = 1'b1;
            ev        = make_event(STATUS_META, 8'h00, 8'h00, 2'd0, 1'b0, DEFAULT_TEMPO);
            phase     = PH_DELTA;
          end
        end
        PH_SYSEX_LEN: begin
          len_accum = {len_accum[24:0], b[6:0]};
          if (!b[7]) begin
            remaining = len_accum;
            len_accum = '0;
            phase     = (remaining == 0) ? PH_DELTA : PH_SYSEX_SKIP;
          end
        end
        PH_SYSEX_SKIP: begin
          remaining = remaining - 32'd1;
          if (remaining == 0) phase = PH_DELTA;
        end
        default: begin
          phase = PH_DELTA;
          again = 1'b1;
        end
      endcase
    end while (again);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      pending_events.delete();
    end else begin
      if (track_in.valid && track_in.ready) begin
        parse_byte(track_in.track_byte, track_in.track_start, produced, predicted);
        if (produced) pending_events.insert(pending_events.size(), predicted);
      end
      if (event_out.valid && event_out.ready) begin
        observed.event_tick   = event_out.event_tick;
        observed.status_value = event_out.status_value;
        observed.first_data   = event_out.first_data;
        observed.second_data  = event_out.second_data;
        observed.data_count   = event_out.data_count;
        observed.is_tempo     = event_out.is_tempo;
        observed.tempo_value  = event_out.tempo_value;
        if (pending_events.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%0t: unexpected event tick %0d status %h", $realtime,
                     observed.event_tick, observed.status_value);
        end else begin
          wanted = pending_events.pop_front();
          if (observed !== wanted) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: event mismatch", $realtime);
              $display("  expected tick %0d status %h data %h %h count %0d tempo %0d %0d",
                       wanted.event_tick, wanted.status_value, wanted.first_data,
                       wanted.second_data, wanted.data_count, wanted.is_tempo,
                       wanted.tempo_value);
              $display("  actual   tick %0d status %h data %h %h count %0d tempo %0d %0d",
                       observed.event_tick, observed.status_value, observed.first_data,
                       observed.second_data, observed.data_count, observed.is_tempo,
                       observed.tempo_value);
            end
          end
        end
      end
    end
    event_errors <= failures;
    events_due   <= pending_events.size();
  end

endmodule

// ===== test/midi_track_event_parser_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser_top_test
// Feeds track bytes into the parser: a short directed stretch for the corner
// cases, then randomly built events with running status, meta, sysex, odd
// statuses and noise. Both channels stall in bursts; the checker beside the
// parser predicts and compares every event.
// ----------------------------------------------------------------------------

module midi_track_event_parser_top_test;
  import mtep_pkg::*;

  localparam int BYTE_TARGET  = 1350;
  localparam int TAIL_START   = 1150;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 90;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DIRECTED_LEN = 35;

  logic       clk;
  logic       rst = 1'b1;
  int         event_errors;
  int         events_due;
  int         bytes_sent  = 0;
  int         cycle_count = 0;
  logic [7:0] last_status = 8'h00;  // running status as the parser should hold it
  logic       start_next  = 1'b0;
  logic       skip_delta  = 1'b0;   // parser already sits where a status is due
  logic       hold_done   = 1'b0;
  logic [8:0] directed_seq [DIRECTED_LEN];

  mtep_in_if  track_in();
  mtep_out_if event_out();

  midi_track_event_parser_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .track_in  (track_in),
    .event_out (event_out)
  );

  midi_track_event_parser_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .track_in     (track_in),
    .event_out    (event_out),
    .event_errors (event_errors),
    .events_due   (events_due)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("midi_track_event_parser_top_test failed");
      $finish;
    end
  end

  // bit 0: sender gaps, bit 1: receiver stalls; quiet near the end
  function automatic int gap_mode();
    return (bytes_sent >= TAIL_START) ? 0 : (bytes_sent / 100) % 4;
  endfunction

  function automatic logic [7:0] data_value();
    return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 127));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (gap_mode() % 2 == 1 && $urandom_range(0, 3) == 0) begin
      track_in.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    track_in.valid       <= 1'b1;
    track_in.track_byte  <= b;
    track_in.track_start <= start_next;
    @(posedge clk);
    while (!track_in.ready) @(posedge clk);
    bytes_sent++;
    start_next = 1'b0;
    @(negedge clk);
  endtask

  // variable-length number, most significant group first
  task automatic send_number(input logic [63:0] value, input int nb);
    for (int i = nb - 1; i >= 0; i--)
      send_byte({(i != 0), 7'(value >> (7 * i))});
  endtask

  task automatic send_event();
    int          kind;
    int          nb;
    int          len;
    int          v;
    logic [7:0]  st;
    logic [7:0]  mtype;
    logic        omit;
    logic        known;
    logic        skip_next;

    skip_next = 1'b0;
    if ($urandom_range(0, 39) == 0) begin
      start_next  = 1'b1;
      last_status = 8'h00;
      skip_delta  = 1'b0;
    end
    known = last_status[7] && (last_status[7:4] <= HI_PITCH || last_status == STATUS_META ||
                               last_status == STATUS_SYSEX || last_status == STATUS_ESCAPE);
    kind = $urandom_range(0, 99);
    if (kind >= 94) begin
      // garbage bytes, then a restart to get back in step
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      start_next  = 1'b1;
      last_status = 8'h00;
    end else begin
      if (!skip_delta) begin
        nb = $urandom_range(0, 19);
        nb = (nb < 12) ? 1 : (nb < 16) ? 2 : (nb < 19) ? $urandom_range(3, 4) :
             $urandom_range(5, 6);
        send_number({$urandom, $urandom}, nb);
      end
      if (kind < 50) begin
        omit = last_status[7:4] >= HI_NOTE_OFF && last_status[7:4] <= HI_PITCH &&
               $urandom_range(0, 1) == 1;
        if (omit) begin
          st = last_status;
        end else begin
          st = {4'($urandom_range(HI_NOTE_OFF, HI_PITCH)), 4'($urandom_range(0, 15))};
          send_byte(st);
          last_status = st;
        end
        // under running status the first data byte must not look like a status
        send_byte(omit ? 8'($urandom_range(0, 127)) : data_value());
        if (st[7:4] != HI_PROGRAM && st[7:4] != HI_CHAN_AT) send_byte(data_value());
      end else if (kind < 65) begin
        omit = last_status == STATUS_META && $urandom_range(0, 1) == 1;
        if (!omit) begin
          send_byte(STATUS_META);
          last_status = STATUS_META;
        end
        mtype = ($urandom_range(0, 1) == 1) ? META_TEMPO :
                8'($urandom_range(0, omit ? 127 : 255));
        len = (mtype == META_TEMPO && $urandom_range(0, 4) != 0) ? 3 : $urandom_range(0, 6);
        send_byte(mtype);
        send_number(64'(len), ($urandom_range(0, 4) == 0) ? 2 : 1);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 75) begin
        omit = (last_status == STATUS_SYSEX || last_status == STATUS_ESCAPE) &&
               $urandom_range(0, 1) == 1;
        if (!omit) begin
          st = ($urandom_range(0, 1) == 1) ? STATUS_SYSEX : STATUS_ESCAPE;
          send_byte(st);
          last_status = st;
        end
        len = $urandom_range(0, 6);
        send_number(64'(len), (!omit && $urandom_range(0, 3) == 0) ? 2 : 1);
        repeat (len) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 88 && !known) begin
        // data byte under an unknown status: event out, byte becomes the next delta
        send_byte(8'($urandom_range(0, 127)));
        skip_next = 1'b1;
      end else begin
        v  = $urandom_range(1, 13);
        st = (v <= 6) ? STATUS_SYSEX + 8'(v) : STATUS_ESCAPE + 8'(v - 6);
        send_byte(st);
        last_status = st;
      end
    end
    skip_delta = skip_next;
  endtask

  // receiver: random stall bursts, plus one long hold-off that fills the parser
  initial begin
    event_out.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && bytes_sent >= HOLD_AT) begin
        event_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else if (gap_mode() >= 2 && $urandom_range(0, 3) == 0) begin
        event_out.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      event_out.ready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    track_in.valid       = 1'b0;
    track_in.track_byte  = 8'h00;
    track_in.track_start = 1'b0;
    // bit 8 marks a track start on that byte
    directed_seq = '{
      9'h1FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F, 9'h090, 9'h085, 9'h0FF,
      9'h000, 9'h0FF, 9'h051, 9'h003, 9'h007, 9'h0A1, 9'h020,
      9'h000, 9'h001, 9'h000,
      9'h000, 9'h0F7, 9'h001, 9'h055,
      9'h000, 9'h000,
      9'h000, 9'h0F1, 9'h000, 9'h005, 9'h0C3, 9'h012,
      9'h100, 9'h007, 9'h0E0, 9'h000, 9'h100
    };
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      start_next = directed_seq[i][8];
      send_byte(directed_seq[i][7:0]);
    end

    start_next  = 1'b1;
    last_status = 8'h00;
    skip_delta  = 1'b0;
    while (bytes_sent < BYTE_TARGET) send_event();
    track_in.valid <= 1'b0;

    while (events_due != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (event_errors == 0) begin
      $display("midi_track_event_parser_top_test passed");
    end else begin
      $display("midi_track_event_parser_top_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mtep_pkg.sv
rtl/mtep_in_if.sv
rtl/mtep_out_if.sv
rtl/midi_track_event_parser_top.sv
test/midi_track_event_parser_checker.sv
test/midi_track_event_parser_top_test.sv
